// ----- rtl/core/ssvf_pkg.sv -----
// shared types, constants and helpers for the stereo state-variable filter
// no dependencies; used by ssvf_ctrl, ssvf_datapath and the top level
`default_nettype none

package ssvf_pkg;

    localparam int SAMPLE_WIDTH_DEFAULT   = 24;
    localparam int COEF_FRAC_BITS_DEFAULT = 24;
    localparam int COEF_WIDTH             = 32;
    localparam int CFG_INDEX_WIDTH        = 3;

    localparam logic [30:0] FREQ_GAIN_RESET = 31'd16777216;

    // register indexes on the configuration port
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FILTER_MODE    = 3'd0,
        CFG_FREQ_GAIN      = 3'd1,
        CFG_FEEDBACK_SUM   = 3'd2,
        CFG_INPUT_NORM     = 3'd3,
        CFG_DAMPING_DOUBLE = 3'd4,
        CFG_DAMPING_QUAD   = 3'd5,
        CFG_SHELF_GAIN     = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        MODE_LOWPASS  = 3'd0,
        MODE_BANDPASS = 3'd1,
        MODE_HIGHPASS = 3'd2,
        MODE_UNIT_BP  = 3'd3,
        MODE_PEAK     = 3'd4,
        MODE_NOTCH    = 3'd5,
        MODE_ALLPASS  = 3'd6,
        MODE_ZERO     = 3'd7
    } mode_t;

    localparam mode_t MODE_RESET = MODE_PEAK;

    // one coefficient product per step, in evaluation order
    typedef enum logic [2:0] {
        STEP_HP_FB   = 3'd0,
        STEP_HP_NORM = 3'd1,
        STEP_BP      = 3'd2,
        STEP_LP      = 3'd3,
        STEP_UBP     = 3'd4,
        STEP_PEAK    = 3'd5,
        STEP_AP      = 3'd6
    } step_t;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_MUL_LO  = 3'd1,
        S_MUL_HI  = 3'd2,
        S_COMBINE = 3'd3,
        S_FINISH  = 3'd4
    } state_t;

    typedef struct packed {
        logic  load;
        logic  mul_lo;
        logic  mul_hi;
        logic  combine;
        logic  finish;
        logic  publish;
        step_t step;
        logic  chan;
    } dp_cmd_t;

    function automatic step_t next_step(input step_t s);
        step_t n;
        unique case (s)
            STEP_HP_FB:   n = STEP_HP_NORM;
            STEP_HP_NORM: n = STEP_BP;
            STEP_BP:      n = STEP_LP;
            STEP_LP:      n = STEP_UBP;
            STEP_UBP:     n = STEP_PEAK;
            STEP_PEAK:    n = STEP_AP;
            default:      n = STEP_AP;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/stereo_state_variable_filter_top.sv -----
// one sample pair is accepted while idle and carried through both channels before
// the next is taken; all coefficient products share the single shared multiplier
//   (7 coefficient products per channel, each formed from two 16-bit partial products
//   and a combine step, then one state-update step per channel)
// reset: rst_n asynchronous active low; states zero, control and configuration registers to their reset values
// depends on ssvf_pkg, ssvf_ctrl and ssvf_datapath
`default_nettype none

module stereo_state_variable_filter_top
#(
    parameter int SAMPLE_WIDTH   = ssvf_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int COEF_FRAC_BITS = ssvf_pkg::COEF_FRAC_BITS_DEFAULT,
    localparam int TDATA_WIDTH   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [TDATA_WIDTH-1:0]              s_tdata,   // left_in, right_in, zero pad
    // output stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [TDATA_WIDTH-1:0]              m_tdata,   // left_out, right_out, zero pad
    // configuration writes
    input  wire logic                                cfg_we,
    input  wire logic [ssvf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [ssvf_pkg::COEF_WIDTH-1:0]     cfg_data
);

    ssvf_pkg::dp_cmd_t       cmd;
    logic [SAMPLE_WIDTH-1:0] left_in, right_in, left_out, right_out;

    // unpack the input transaction, padding bits are ignored
    assign left_in  = s_tdata[SAMPLE_WIDTH-1:0];
    assign right_in = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

    // sequencer: accepts one transaction while idle, walks both channels through
    // the product steps, then hands the pair to the output register
    ssvf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // arithmetic, coefficients and the four integrator states
    ssvf_datapath
    #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .left_in   (left_in),
        .right_in  (right_in),
        .left_out  (left_out),
        .right_out (right_out)
    );

    // pack the result pair, zero fill to whole bytes
    assign m_tdata = TDATA_WIDTH'({right_out, left_out});

endmodule

`default_nettype wire

// ----- rtl/core/ssvf_ctrl.sv -----
// sequencer for the stereo state-variable filter: handshakes and step order
// depends on ssvf_pkg
`default_nettype none

module ssvf_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output ssvf_pkg::dp_cmd_t      cmd
);

    ssvf_pkg::state_t state_reg, state_next;
    ssvf_pkg::step_t  step_reg, step_next;
    logic             chan_reg, chan_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             accept;

    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && (state_reg == ssvf_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssvf_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ssvf_pkg::S_MUL_LO;
                end
            end
            ssvf_pkg::S_MUL_LO:  state_next = ssvf_pkg::S_MUL_HI;
            ssvf_pkg::S_MUL_HI:  state_next = ssvf_pkg::S_COMBINE;
            ssvf_pkg::S_COMBINE:
            begin
                if (step_reg == ssvf_pkg::STEP_AP)
                begin
                    state_next = ssvf_pkg::S_FINISH;
                end
                else
                begin
                    state_next = ssvf_pkg::S_MUL_LO;
                end
            end
            ssvf_pkg::S_FINISH:
            begin
                if (!chan_reg)
                begin
                    state_next = ssvf_pkg::S_MUL_LO;
                end
                else if (out_free)
                begin
                    state_next = ssvf_pkg::S_IDLE;
                end
            end
            default: state_next = ssvf_pkg::S_IDLE;
        endcase
    end

    // step and channel counters, output valid flag
    always_comb
    begin
        step_next      = step_reg;
        chan_next      = chan_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        priority if (accept)
        begin
            step_next = ssvf_pkg::STEP_HP_FB;
            chan_next = 1'b0;
        end
        else if (state_reg == ssvf_pkg::S_COMBINE && step_reg != ssvf_pkg::STEP_AP)
        begin
            step_next = ssvf_pkg::next_step(step_reg);
        end
        else if (state_reg == ssvf_pkg::S_FINISH && !chan_reg)
        begin
            step_next = ssvf_pkg::STEP_HP_FB;
            chan_next = 1'b1;
        end
        else if (state_reg == ssvf_pkg::S_FINISH && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            step_next = step_reg;
        end
    end

    // outputs
    always_comb
    begin
        s_tready     = (state_reg == ssvf_pkg::S_IDLE);
        m_tvalid     = out_valid_reg;
        cmd.load     = accept;
        cmd.mul_lo   = (state_reg == ssvf_pkg::S_MUL_LO);
        cmd.mul_hi   = (state_reg == ssvf_pkg::S_MUL_HI);
        cmd.combine  = (state_reg == ssvf_pkg::S_COMBINE);
        cmd.finish   = (state_reg == ssvf_pkg::S_FINISH) && (!chan_reg || out_free);
        cmd.publish  = (state_reg == ssvf_pkg::S_FINISH) && chan_reg && out_free;
        cmd.step     = step_reg;
        cmd.chan     = chan_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssvf_pkg::S_IDLE;
            step_reg      <= ssvf_pkg::STEP_HP_FB;
            chan_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || m_tready))
        else $error("result published over an untaken result");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ssvf_pkg::S_MUL_LO &&
            step_reg == ssvf_pkg::STEP_HP_FB && !chan_reg))
        else $error("item did not start at first step of left channel");

    a_lo_then_hi: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssvf_pkg::S_MUL_LO) |=> (state_reg == ssvf_pkg::S_MUL_HI))
        else $error("low partial product not followed by high one");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_lo, cmd.mul_hi, cmd.combine, cmd.finish}))
        else $error("more than one datapath command at once");

endmodule

`default_nettype wire

// ----- rtl/core/ssvf_datapath.sv -----
// datapath of the stereo state-variable filter: registers, shared multiplier,
// saturating adders and filter states; depends on ssvf_pkg
`default_nettype none

module ssvf_datapath
#(
    parameter int SAMPLE_WIDTH   = ssvf_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int COEF_FRAC_BITS = ssvf_pkg::COEF_FRAC_BITS_DEFAULT
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [ssvf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [ssvf_pkg::COEF_WIDTH-1:0]     cfg_data,
    input  wire ssvf_pkg::dp_cmd_t                   cmd,
    input  wire logic [SAMPLE_WIDTH-1:0]             left_in,
    input  wire logic [SAMPLE_WIDTH-1:0]             right_in,
    output logic      [SAMPLE_WIDTH-1:0]             left_out,
    output logic      [SAMPLE_WIDTH-1:0]             right_out
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int ACC = SAMPLE_WIDTH + 8;
    localparam int MW  = ACC + 33;
    localparam int CW  = ssvf_pkg::COEF_WIDTH;

    localparam logic signed [MW-1:0] ACC_MAX_W = {{(MW-ACC+1){1'b0}}, {(ACC-1){1'b1}}};
    localparam logic signed [MW-1:0] ACC_MIN_W = ~ACC_MAX_W;
    localparam logic signed [ACC-1:0] OUT_MAX_A = {{(ACC-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [ACC-1:0] OUT_MIN_A = ~OUT_MAX_A;
    localparam logic signed [MW-1:0] ROUND_W =
        {{(MW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

    function automatic logic signed [MW-1:0] ext_mw(input logic signed [ACC-1:0] v);
        return {{(MW-ACC){v[ACC-1]}}, v};
    endfunction

    function automatic logic signed [ACC-1:0] sat_acc(input logic signed [MW-1:0] v);
        if (v > ACC_MAX_W)
        begin
            return ACC_MAX_W[ACC-1:0];
        end
        else if (v < ACC_MIN_W)
        begin
            return ACC_MIN_W[ACC-1:0];
        end
        return v[ACC-1:0];
    endfunction

    function automatic logic [SW-1:0] sat_out(input logic signed [ACC-1:0] v);
        if (v > OUT_MAX_A)
        begin
            return OUT_MAX_A[SW-1:0];
        end
        else if (v < OUT_MIN_A)
        begin
            return OUT_MIN_A[SW-1:0];
        end
        return v[SW-1:0];
    endfunction

    // configuration
    ssvf_pkg::mode_t   mode_reg;
    logic [30:0]       freq_gain_reg, feedback_sum_reg, input_norm_reg;
    logic [30:0]       damping_double_reg, damping_quad_reg;
    logic [CW-1:0]     shelf_gain_reg;

    // samples and intermediates
    logic signed [SW-1:0]  xl_reg, xr_reg;
    logic signed [ACC-1:0] hp_reg, bp_reg, lp_reg, ubp_reg, peak_reg, ap_reg;
    logic signed [ACC-1:0] gh_reg, gb_reg;
    logic signed [ACC-1:0] hp_next, bp_next, lp_next, ubp_next, peak_next, ap_next;
    logic signed [ACC-1:0] gh_next, gb_next;
    logic signed [MW-1:0]  lo_acc_reg, lo_acc_next, sum_reg, sum_next;
    logic [SW-1:0]         left_y_reg, left_y_next;
    logic [SW-1:0]         left_out_reg, left_out_next, right_out_reg, right_out_next;

    // filter states
    logic signed [ACC-1:0] z1l_reg, z2l_reg, z1r_reg, z2r_reg;
    logic signed [ACC-1:0] z1l_next, z2l_next, z1r_next, z2r_next;

    logic signed [ACC-1:0] x_cur, z1_cur, z2_cur;
    logic signed [ACC-1:0] a_sel, prod, z1_upd, z2_upd, notch, y_sel;
    logic [CW-1:0]         c_sel;
    logic signed [16:0]    c_part;
    logic signed [ACC+16:0] mul_prod;
    logic signed [MW-1:0]  prod_shift;
    logic [SW-1:0]         y_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= ssvf_pkg::MODE_RESET;
            freq_gain_reg      <= ssvf_pkg::FREQ_GAIN_RESET;
            feedback_sum_reg   <= '0;
            input_norm_reg     <= '0;
            damping_double_reg <= '0;
            damping_quad_reg   <= '0;
            shelf_gain_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssvf_pkg::CFG_FILTER_MODE:    mode_reg <= ssvf_pkg::mode_t'(cfg_data[2:0]);
                ssvf_pkg::CFG_FREQ_GAIN:      freq_gain_reg <= cfg_data[30:0];
                ssvf_pkg::CFG_FEEDBACK_SUM:   feedback_sum_reg <= cfg_data[30:0];
                ssvf_pkg::CFG_INPUT_NORM:     input_norm_reg <= cfg_data[30:0];
                ssvf_pkg::CFG_DAMPING_DOUBLE: damping_double_reg <= cfg_data[30:0];
                ssvf_pkg::CFG_DAMPING_QUAD:   damping_quad_reg <= cfg_data[30:0];
                ssvf_pkg::CFG_SHELF_GAIN:     shelf_gain_reg <= cfg_data;
                default:                      mode_reg <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xl_reg <= left_in;
            xr_reg <= right_in;
        end
    end

    assign x_cur  = cmd.chan ? {{(ACC-SW){xr_reg[SW-1]}}, xr_reg}
                             : {{(ACC-SW){xl_reg[SW-1]}}, xl_reg};
    assign z1_cur = cmd.chan ? z1r_reg : z1l_reg;
    assign z2_cur = cmd.chan ? z2r_reg : z2l_reg;

    // operand and coefficient for the current step
    always_comb
    begin
        unique case (cmd.step)
            ssvf_pkg::STEP_HP_FB:   begin a_sel = z1_cur;  c_sel = {1'b0, feedback_sum_reg};   end
            ssvf_pkg::STEP_HP_NORM: begin a_sel = hp_reg;  c_sel = {1'b0, input_norm_reg};     end
            ssvf_pkg::STEP_BP:      begin a_sel = hp_reg;  c_sel = {1'b0, freq_gain_reg};      end
            ssvf_pkg::STEP_LP:      begin a_sel = bp_reg;  c_sel = {1'b0, freq_gain_reg};      end
            ssvf_pkg::STEP_UBP:     begin a_sel = bp_reg;  c_sel = {1'b0, damping_double_reg}; end
            ssvf_pkg::STEP_PEAK:    begin a_sel = ubp_reg; c_sel = shelf_gain_reg;             end
            ssvf_pkg::STEP_AP:      begin a_sel = bp_reg;  c_sel = {1'b0, damping_quad_reg};   end
            default:                begin a_sel = bp_reg;  c_sel = {1'b0, damping_quad_reg};   end
        endcase
    end

    // shared multiplier: low 16 coefficient bits, then the signed high half
    assign c_part   = cmd.mul_hi ? $signed({c_sel[CW-1], c_sel[CW-1:16]})
                                 : $signed({1'b0, c_sel[15:0]});
    assign mul_prod = a_sel * c_part;

    assign lo_acc_next = cmd.mul_lo ? ({{(MW-ACC-17){mul_prod[ACC+16]}}, mul_prod} + ROUND_W)
                                    : lo_acc_reg;
    assign sum_next    = cmd.mul_hi ? (({{(MW-ACC-17){mul_prod[ACC+16]}}, mul_prod} <<< 16)
                                       + lo_acc_reg)
                                    : sum_reg;

    assign prod_shift = sum_reg >>> COEF_FRAC_BITS;
    assign prod       = sat_acc(prod_shift);

    // combine step
    always_comb
    begin
        hp_next   = hp_reg;
        bp_next   = bp_reg;
        lp_next   = lp_reg;
        ubp_next  = ubp_reg;
        peak_next = peak_reg;
        ap_next   = ap_reg;
        gh_next   = gh_reg;
        gb_next   = gb_reg;
        if (cmd.combine)
        begin
            unique case (cmd.step)
                ssvf_pkg::STEP_HP_FB:
                    hp_next = sat_acc(ext_mw(x_cur) - ext_mw(prod) - ext_mw(z2_cur));
                ssvf_pkg::STEP_HP_NORM:
                    hp_next = prod;
                ssvf_pkg::STEP_BP:
                begin
                    gh_next = prod;
                    bp_next = sat_acc(ext_mw(prod) + ext_mw(z1_cur));
                end
                ssvf_pkg::STEP_LP:
                begin
                    gb_next = prod;
                    lp_next = sat_acc(ext_mw(prod) + ext_mw(z2_cur));
                end
                ssvf_pkg::STEP_UBP:
                    ubp_next = prod;
                ssvf_pkg::STEP_PEAK:
                    peak_next = sat_acc(ext_mw(x_cur) + ext_mw(prod));
                ssvf_pkg::STEP_AP:
                    ap_next = sat_acc(ext_mw(x_cur) - ext_mw(prod));
                default:
                    ap_next = ap_reg;
            endcase
        end
    end

    // state update and output selection
    assign z1_upd = sat_acc(ext_mw(gh_reg) + ext_mw(bp_reg));
    assign z2_upd = sat_acc(ext_mw(gb_reg) + ext_mw(lp_reg));
    assign notch  = sat_acc(ext_mw(x_cur) - ext_mw(ubp_reg));

    always_comb
    begin
        unique case (mode_reg)
            ssvf_pkg::MODE_LOWPASS:  y_sel = lp_reg;
            ssvf_pkg::MODE_BANDPASS: y_sel = bp_reg;
            ssvf_pkg::MODE_HIGHPASS: y_sel = hp_reg;
            ssvf_pkg::MODE_UNIT_BP:  y_sel = ubp_reg;
            ssvf_pkg::MODE_PEAK:     y_sel = peak_reg;
            ssvf_pkg::MODE_NOTCH:    y_sel = notch;
            ssvf_pkg::MODE_ALLPASS:  y_sel = ap_reg;
            ssvf_pkg::MODE_ZERO:     y_sel = '0;
            default:                 y_sel = '0;
        endcase
    end

    assign y_sat = sat_out(y_sel);

    always_comb
    begin
        z1l_next       = z1l_reg;
        z2l_next       = z2l_reg;
        z1r_next       = z1r_reg;
        z2r_next       = z2r_reg;
        left_y_next    = left_y_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        if (cmd.finish && !cmd.chan)
        begin
            z1l_next    = z1_upd;
            z2l_next    = z2_upd;
            left_y_next = y_sat;
        end
        if (cmd.finish && cmd.chan)
        begin
            z1r_next = z1_upd;
            z2r_next = z2_upd;
        end
        if (cmd.publish)
        begin
            left_out_next  = left_y_reg;
            right_out_next = y_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z1l_reg <= '0;
            z2l_reg <= '0;
            z1r_reg <= '0;
            z2r_reg <= '0;
        end
        else
        begin
            z1l_reg <= z1l_next;
            z2l_reg <= z2l_next;
            z1r_reg <= z1r_next;
            z2r_reg <= z2r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_acc_reg    <= lo_acc_next;
        sum_reg       <= sum_next;
        hp_reg        <= hp_next;
        bp_reg        <= bp_next;
        lp_reg        <= lp_next;
        ubp_reg       <= ubp_next;
        peak_reg      <= peak_next;
        ap_reg        <= ap_next;
        gh_reg        <= gh_next;
        gb_reg        <= gb_next;
        left_y_reg    <= left_y_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
    end

    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

`default_nettype wire
